// ----- design/hrgp_pkg.sv -----
// shared types and constants for the hsv/rgb to pwm duty converter
`timescale 1ns / 1ps
`default_nettype none

package hrgp_pkg;

  // command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_RGB   = 2'd1,
    CMD_HSV   = 2'd2
  } cmd_t;

  localparam int LEVEL_W     = 8;
  localparam int OUT_W       = 11;
  localparam int VALUE_W     = 11;
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CHANNELS    = 3;

  // stages inside the hsv arithmetic pipe, input register included
  localparam int HSV_STAGES  = 6;

  localparam logic [LEVEL_W-1:0] FULL        = 8'd255;
  localparam logic [15:0]        FULL_SQ     = 16'd65025;
  localparam logic [2:0]         LAST_SECTOR = 3'd5;
  // 2^24 / 65025 rounded down, quotient estimate is exact or one low
  localparam logic [8:0]         RECIP_SQ    = 9'd258;

  // one accepted input word
  typedef struct packed {
    cmd_t                 cmd;
    logic [LEVEL_W-1:0]   c0;
    logic [LEVEL_W-1:0]   c1;
    logic [LEVEL_W-1:0]   c2;
    logic [ADDR_W-1:0]    idx;
    logic [VALUE_W-1:0]   val;
  } item_t;

  // table access request leaving the arithmetic pipe
  typedef struct packed {
    cmd_t                               cmd;
    logic [CHANNELS-1:0][LEVEL_W-1:0]   lvl;
    logic [ADDR_W-1:0]                  idx;
    logic [VALUE_W-1:0]                 val;
  } req_t;

endpackage

`default_nettype wire

// ----- design/hsv_to_rgb_gamma_pwm_top.sv -----
// hsv or rgb colour to pwm duty converter with a loadable brightness table
// the result passes the hsv stage registers r0 to r5 and then the table read registers
// throughput: one word per cycle while the output is not stalled; the three table lookups use three copies of the table
// a stalled output only holds the stages that are full, empty stages keep filling
// reset clears the pipeline valid flags; table contents are undefined until written
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_gamma_pwm_top #(
  parameter int DUTY_BITS = 11
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // first_channel, second_channel, third_channel, entry_index, entry_value, zero pad
  input  wire logic [47:0] s_tdata,
  // command
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // duty_red, duty_green, duty_blue, zero pad
  output logic [39:0]      m_tdata
);

  localparam int NST = hrgp_pkg::HSV_STAGES + 1;

  logic [NST-1:0]          vld;
  logic [NST-1:0]          en;
  logic                    conv;
  hrgp_pkg::item_t         in_item;
  hrgp_pkg::req_t          req;
  logic                    tbl_we;
  logic [DUTY_BITS+hrgp_pkg::VALUE_W-1:0] wr_wide;
  logic [DUTY_BITS-1:0]    wr_data;
  logic [DUTY_BITS-1:0]    rd_data [hrgp_pkg::CHANNELS];
  logic [DUTY_BITS+hrgp_pkg::OUT_W-1:0]   rd_wide [hrgp_pkg::CHANNELS];
  logic [hrgp_pkg::OUT_W-1:0]             duty    [hrgp_pkg::CHANNELS];

  // unpack the input word
  always_comb begin
    in_item.cmd = hrgp_pkg::cmd_t'(s_tuser);
    in_item.c0  = s_tdata[7:0];
    in_item.c1  = s_tdata[15:8];
    in_item.c2  = s_tdata[23:16];
    in_item.idx = s_tdata[31:24];
    in_item.val = s_tdata[42:32];
  end

  // stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NST-1] = !m_tvalid || m_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[0];

  // valid flags along the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      conv <= 1'b0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (en[NST-1]) begin
        conv <= vld[NST-2] &&
                (req.cmd == hrgp_pkg::CMD_RGB || req.cmd == hrgp_pkg::CMD_HSV);
      end
    end
  end

  hrgp_hsv u_hsv (
    .clk     (clk),
    .en      (en[hrgp_pkg::HSV_STAGES-1:0]),
    .in_item (in_item),
    .req     (req)
  );

  // table write happens at the same stage as the reads, so program order holds
  assign tbl_we  = en[NST-1] && vld[NST-2] && (req.cmd == hrgp_pkg::CMD_WRITE);
  assign wr_wide = {{DUTY_BITS{1'b0}}, req.val};
  assign wr_data = wr_wide[DUTY_BITS-1:0];

  // one table copy per colour channel
  for (genvar c = 0; c < hrgp_pkg::CHANNELS; c++) begin : g_tbl
    hrgp_ram #(
      .DATA_W (DUTY_BITS)
    ) u_ram (
      .clk   (clk),
      .we    (tbl_we),
      .waddr (req.idx),
      .wdata (wr_data),
      .re    (en[NST-1]),
      .raddr (req.lvl[c]),
      .rdata (rd_data[c])
    );

    assign rd_wide[c] = {{hrgp_pkg::OUT_W{1'b0}}, rd_data[c]};
    assign duty[c]    = rd_wide[c][hrgp_pkg::OUT_W-1:0];
  end

  // output word straight from the table read registers
  assign m_tvalid = vld[NST-1] && conv;
  assign m_tdata  = {7'b0, duty[2], duty[1], duty[0]};

endmodule

`default_nettype wire

// ----- design/hrgp_ram.sv -----
// one copy of the brightness table, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module hrgp_ram #(
  parameter int DATA_W = 11
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [hrgp_pkg::ADDR_W-1:0]   waddr,
  input  wire logic [DATA_W-1:0]             wdata,
  input  wire logic                          re,
  input  wire logic [hrgp_pkg::ADDR_W-1:0]   raddr,
  output logic      [DATA_W-1:0]             rdata
);

  logic [DATA_W-1:0] mem [hrgp_pkg::TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/hrgp_hsv.sv -----
// pipelined hsv to level arithmetic, passes rgb and table writes alongside
`timescale 1ns / 1ps
`default_nettype none

module hrgp_hsv (
  input  wire logic                                clk,
  input  wire logic [hrgp_pkg::HSV_STAGES-1:0]     en,
  input  wire hrgp_pkg::item_t                     in_item,
  output hrgp_pkg::req_t                           req
);

  typedef struct packed {
    hrgp_pkg::item_t item;
    logic [2:0]      sector;
    logic [7:0]      f;
    logic [15:0]     pprod;
  } st1_t;

  typedef struct packed {
    hrgp_pkg::item_t item;
    logic [2:0]      sector;
    logic [7:0]      p;
    logic [15:0]     sf;
    logic [15:0]     sg;
  } st2_t;

  typedef struct packed {
    hrgp_pkg::item_t item;
    logic [2:0]      sector;
    logic [7:0]      p;
    logic [23:0]     xq;
    logic [23:0]     xt;
  } st3_t;

  typedef struct packed {
    hrgp_pkg::item_t item;
    logic [2:0]      sector;
    logic [7:0]      p;
    logic [23:0]     xq;
    logic [23:0]     xt;
    logic [7:0]      eq;
    logic [7:0]      et;
  } st4_t;

  typedef struct packed {
    hrgp_pkg::item_t item;
    logic [2:0]      sector;
    logic [7:0]      p;
    logic [7:0]      q;
    logic [7:0]      t;
  } st5_t;

  hrgp_pkg::item_t r0;
  st1_t r1, r1_next;
  st2_t r2, r2_next;
  st3_t r3, r3_next;
  st4_t r4, r4_next;
  st5_t r5, r5_next;

  logic [10:0] h6;
  logic [10:0] hsum;
  logic [2:0]  sec_raw;
  logic [10:0] f_full;
  logic [16:0] psum;
  logic [31:0] mq;
  logic [31:0] mt;
  logic [23:0] bq;
  logic [23:0] bt;
  logic [23:0] rq;
  logic [23:0] rt;

  // sector and fraction: h*6 / 255 by add and shift, exact for every 8-bit h
  always_comb begin
    h6      = 11'({r0.c0, 2'b00}) + 11'({r0.c0, 1'b0});
    hsum    = h6 + 11'd1 + 11'(h6[10:8]);
    sec_raw = hsum[10:8];
    f_full  = h6 - 11'({sec_raw, 8'b0}) + 11'(sec_raw);
    r1_next.item   = r0;
    r1_next.sector = (sec_raw > hrgp_pkg::LAST_SECTOR) ? hrgp_pkg::LAST_SECTOR : sec_raw;
    r1_next.f      = f_full[7:0];
    r1_next.pprod  = 16'(r0.c2) * 16'(hrgp_pkg::FULL - r0.c1);
  end

  // p = v*(255-s)/255, and the two saturation products
  always_comb begin
    psum = 17'(r1.pprod) + 17'd1 + 17'(r1.pprod[15:8]);
    r2_next.item   = r1.item;
    r2_next.sector = r1.sector;
    r2_next.p      = psum[15:8];
    r2_next.sf     = 16'(r1.item.c1) * 16'(r1.f);
    r2_next.sg     = 16'(r1.item.c1) * 16'(hrgp_pkg::FULL - r1.f);
  end

  // numerators of q and t, both below 2^24
  always_comb begin
    r3_next.item   = r2.item;
    r3_next.sector = r2.sector;
    r3_next.p      = r2.p;
    r3_next.xq     = 24'(r2.item.c2) * 24'(hrgp_pkg::FULL_SQ - r2.sf);
    r3_next.xt     = 24'(r2.item.c2) * 24'(hrgp_pkg::FULL_SQ - r2.sg);
  end

  // reciprocal estimate of x / 65025
  always_comb begin
    mq = 32'(r3.xq) * 32'(hrgp_pkg::RECIP_SQ);
    mt = 32'(r3.xt) * 32'(hrgp_pkg::RECIP_SQ);
    r4_next.item   = r3.item;
    r4_next.sector = r3.sector;
    r4_next.p      = r3.p;
    r4_next.xq     = r3.xq;
    r4_next.xt     = r3.xt;
    r4_next.eq     = mq[31:24];
    r4_next.et     = mt[31:24];
  end

  // correct the estimate by one where the remainder is still a full divisor
  always_comb begin
    bq = 24'(r4.eq) * 24'(hrgp_pkg::FULL_SQ);
    bt = 24'(r4.et) * 24'(hrgp_pkg::FULL_SQ);
    rq = r4.xq - bq;
    rt = r4.xt - bt;
    r5_next.item   = r4.item;
    r5_next.sector = r4.sector;
    r5_next.p      = r4.p;
    r5_next.q      = r4.eq + 8'(rq >= 24'(hrgp_pkg::FULL_SQ));
    r5_next.t      = r4.et + 8'(rt >= 24'(hrgp_pkg::FULL_SQ));
  end

  // stage registers, each moves on its own enable
  always_ff @(posedge clk) begin
    if (en[0]) r0 <= in_item;
    if (en[1]) r1 <= r1_next;
    if (en[2]) r2 <= r2_next;
    if (en[3]) r3 <= r3_next;
    if (en[4]) r4 <= r4_next;
    if (en[5]) r5 <= r5_next;
  end

  // level selection; zero saturation already gives p = q = t = v
  always_comb begin
    req.cmd = r5.item.cmd;
    req.idx = r5.item.idx;
    req.val = r5.item.val;
    req.lvl = {r5.item.c2, r5.item.c1, r5.item.c0};
    if (r5.item.cmd == hrgp_pkg::CMD_HSV) begin
      case (r5.sector)
        3'd0:    req.lvl = {r5.p, r5.t, r5.item.c2};
        3'd1:    req.lvl = {r5.p, r5.item.c2, r5.q};
        3'd2:    req.lvl = {r5.t, r5.item.c2, r5.p};
        3'd3:    req.lvl = {r5.item.c2, r5.q, r5.p};
        3'd4:    req.lvl = {r5.item.c2, r5.p, r5.t};
        default: req.lvl = {r5.q, r5.p, r5.item.c2};
      endcase
    end
  end

endmodule

`default_nettype wire
